/* rtl/arh_pkg.sv */
// Shared types and constants for the auto-rebinning histogram.
package arh_pkg;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [1:0] CFG_LOG_SCALE = 2'd0;
    localparam logic [1:0] CFG_INIT_SIZE = 2'd1;
    localparam logic [1:0] CFG_BINS      = 2'd2;

    localparam int WIDTH_W = 48;

    // input word
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] sample;
        logic [5:0]  bin_select;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [5:0]  bin_number;
        logic [31:0] bin_value;
        logic [63:0] samples_seen;
        logic [31:0] largest_sample;
        logic [63:0] running_sum;
        logic [63:0] running_square_sum;
        logic [5:0]  top_bin;
        logic [47:0] current_width;
    } t_out_word;

    // configuration write
    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] data;
    } t_cfg_word;

endpackage

/* rtl/arh_if.sv */
// Valid/ready channel interfaces for the histogram.
interface arh_in_if;
    import arh_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface arh_out_if;
    import arh_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface arh_cfg_if;
    import arh_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/arh_front.sv */
// Front end: accepts words, updates running statistics, queues commands.
module arh_front #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clear_stats,
    input  logic               i_valid,
    output logic               o_ready,
    input  arh_pkg::t_in_word  i_word,
    output logic               o_valid,
    input  logic               i_ready,
    output arh_pkg::t_in_word  o_word,
    output logic [31:0]        o_max,
    output logic [63:0]        o_tally,
    output logic [63:0]        o_sum,
    output logic [63:0]        o_sq
);
    import arh_pkg::*;

    // two-entry queue toward the back end
    t_in_word    r_q [2];
    logic [1:0]  r_cnt;
    logic        r_wp, r_rp;
    logic [SAMPLE_WIDTH-1:0] r_max;
    logic [63:0] r_tally, r_sum, r_sq;
    logic        take, give;
    logic [SAMPLE_WIDTH-1:0] v;
    logic [63:0] sq;

    assign o_ready = (r_cnt != 2'd2);
    assign take    = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign give    = o_valid && i_ready;
    assign o_word  = r_q[r_rp];
    assign v       = o_word.sample[SAMPLE_WIDTH-1:0];
    assign sq      = 64'(v) * 64'(v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_wp <= 1'b0; r_rp <= 1'b0;
        end else begin
            if (take) r_wp <= ~r_wp;
            if (give) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(take) - 2'(give);
        end
        if (take) r_q[r_wp] <= i_word;
    end

    // statistics follow the word as it moves to the back end, so a result
    // shows the totals up to and including its own word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear_stats) begin
            r_max <= '0; r_tally <= '0; r_sum <= '0; r_sq <= '0;
        end else if (give && o_word.mode == MODE_ADD) begin
            if (v > r_max) r_max <= v;
            r_tally <= r_tally + 64'd1;
            r_sum   <= r_sum + 64'(v);
            r_sq    <= r_sq + sq;
        end else if (give && o_word.mode == MODE_CLEAR) begin
            r_max <= '0; r_tally <= '0; r_sum <= '0; r_sq <= '0;
        end
    end

    assign o_max   = 32'(r_max);
    assign o_tally = r_tally;
    assign o_sum   = r_sum;
    assign o_sq    = r_sq;
endmodule

/* rtl/arh_back.sv */
// Back end: bin memory, rebinning sweep, clear sweep and result register.
module arh_back #(
    parameter int MAX_BINS     = 64,
    parameter int COUNT_WIDTH  = 32,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_log_scale,
    input  logic [15:0]        i_init_size,
    input  logic [6:0]         i_bins,
    input  logic               i_valid,
    output logic               o_ready,
    input  arh_pkg::t_in_word  i_word,
    input  logic [31:0]        i_max,
    input  logic [63:0]        i_tally,
    input  logic [63:0]        i_sum,
    input  logic [63:0]        i_sq,
    output logic               o_valid,
    input  logic               i_ready,
    output arh_pkg::t_out_word o_word
);
    import arh_pkg::*;

    localparam int IW = $clog2(MAX_BINS);
    localparam int NW = IW + 1;
    localparam int VW = $clog2(SAMPLE_WIDTH);
    localparam logic [NW-1:0] NMAX = NW'(MAX_BINS);
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_CHK = 4'd2,
        S_M0 = 4'd3, S_M1 = 4'd4, S_M2 = 4'd5, S_MZ = 4'd6, S_IDX = 4'd7,
        S_RD = 4'd8, S_WR = 4'd9, S_CLR = 4'd10, S_OUT = 4'd11, S_INIT = 4'd12;

    logic [COUNT_WIDTH-1:0] mem [MAX_BINS];
    logic [COUNT_WIDTH-1:0] r_rdata, r_a;
    logic [3:0]   r_st;
    logic [NW-1:0] r_i;
    logic [IW-1:0] r_idx;
    logic [WIDTH_W-1:0] r_w;
    logic [IW-1:0] r_top;
    t_in_word     r_cmd;
    logic         r_ov;
    t_out_word    r_out;
    logic [5:0]   r_num;
    logic [31:0]  r_val;
    logic [NW-1:0] n_act;
    logic [NW-1:0] bins_c;
    logic [WIDTH_W+NW-1:0] lim;
    logic [5:0]   lg;
    logic [COUNT_WIDTH:0] msum;
    logic [SAMPLE_WIDTH-1:0] v;
    logic [WIDTH_W-1:0] quo;
    logic         mem_we;
    logic [IW-1:0] mem_wa, mem_ra;
    logic [COUNT_WIDTH-1:0] mem_wd;
    logic         out_load;
    // division by the bin width: a restoring divider, one quotient bit a cycle
    logic [5:0]   r_dc;
    logic [WIDTH_W-1:0] r_rem, r_quo;
    logic [WIDTH_W-1:0] dsh;

    // active bin count: clamp, even, at least two
    always_comb begin
        bins_c = (32'(i_bins) > 32'(MAX_BINS)) ? NMAX : NW'(i_bins);
        n_act = {bins_c[NW-1:1], 1'b0};
        if (n_act < NW'(2)) n_act = NW'(2);
    end

    assign v   = r_cmd.sample[SAMPLE_WIDTH-1:0];
    assign lim = (WIDTH_W+NW)'(n_act) * (WIDTH_W+NW)'(r_w);

    // floor(log2)+1 of the sample, sweep-free priority search
    always_comb begin
        lg = '0;
        for (int k = 0; k < SAMPLE_WIDTH; k++)
            if (v[k]) lg = 6'(k + 1);
    end

    assign msum = {1'b0, r_a} + {1'b0, r_rdata};
    assign dsh  = {r_rem[WIDTH_W-2:0], v[VW'(r_dc - 6'd1)]};
    assign quo  = r_quo;

    always_comb begin
        mem_we = 1'b0; mem_wa = r_i[IW-1:0]; mem_wd = '0; mem_ra = r_i[IW-1:0];
        case (r_st)
            S_M0:    mem_ra = IW'({r_i, 1'b0});
            S_M1:    mem_ra = IW'({r_i, 1'b1});
            S_M2: begin
                mem_we = 1'b1; mem_wa = r_i[IW-1:0];
                mem_wd = msum[COUNT_WIDTH] ? CMAX : msum[COUNT_WIDTH-1:0];
            end
            S_MZ, S_CLR, S_INIT: begin
                mem_we = 1'b1; mem_wa = r_i[IW-1:0];
            end
            S_IDX, S_RD: mem_ra = r_idx;
            S_WR: begin
                mem_we = (r_cmd.mode == MODE_ADD) && (r_rdata != CMAX);
                mem_wa = r_idx; mem_wd = r_rdata + COUNT_WIDTH'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rdata <= mem[mem_ra];
    end

    // the result register frees the back end while a result waits
    assign out_load = (r_st == S_OUT) && (!r_ov || i_ready);
    assign o_ready  = (r_st == S_IDLE);
    assign o_valid  = r_ov;
    assign o_word   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_INIT; r_i <= '0; r_ov <= 1'b0; r_top <= '0;
            r_w <= WIDTH_W'(1);
        end else begin
            if (out_load) r_ov <= 1'b1;
            else if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_st)
                S_INIT: begin
                    r_i <= r_i + NW'(1);
                    if (r_i == NMAX - NW'(1)) begin
                        r_st <= S_IDLE;
                        r_w <= (i_init_size == 16'd0) ? WIDTH_W'(1) : WIDTH_W'(i_init_size);
                    end
                end
                S_IDLE: if (i_valid) begin
                    r_cmd <= i_word; r_st <= S_DEC;
                end
                S_DEC: begin
                    r_i <= '0;
                    case (r_cmd.mode)
                        MODE_ADD: r_st <= i_log_scale ? S_IDX : S_CHK;
                        MODE_READ: begin
                            r_idx <= IW'(r_cmd.bin_select);
                            r_st  <= S_RD;
                        end
                        MODE_CLEAR: r_st <= S_CLR;
                        default: begin
                            r_num <= '0; r_val <= '0;
                            r_st  <= S_OUT;
                        end
                    endcase
                    if (r_cmd.mode == MODE_ADD && i_log_scale)
                        r_idx <= (32'(lg) >= 32'(n_act)) ? IW'(n_act - NW'(1)) : IW'(lg);
                end
                S_CHK: begin
                    r_i <= '0;
                    if ((WIDTH_W+NW)'(i_max) >= lim) r_st <= S_M0;
                    else begin
                        r_st <= S_IDX; r_dc <= 6'(SAMPLE_WIDTH); r_rem <= '0; r_quo <= '0;
                    end
                end
                S_M0: r_st <= S_M1;
                S_M1: begin r_a <= r_rdata; r_st <= S_M2; end
                S_M2: begin
                    if (r_i == (n_act >> 1) - NW'(1)) r_st <= S_MZ;
                    else r_st <= S_M0;
                    r_i <= r_i + NW'(1);
                end
                S_MZ: begin
                    r_i <= r_i + NW'(1);
                    if (r_i == n_act - NW'(1)) begin
                        r_w <= r_w << 1; r_st <= S_CHK;
                    end
                end
                S_IDX: begin
                    if (i_log_scale) r_st <= S_RD;
                    else if (r_dc != 6'd0) begin
                        // shift in next sample bit, subtract if possible
                        if (dsh >= r_w) begin
                            r_rem <= dsh - r_w;
                            r_quo <= {r_quo[WIDTH_W-2:0], 1'b1};
                        end else begin
                            r_rem <= dsh;
                            r_quo <= {r_quo[WIDTH_W-2:0], 1'b0};
                        end
                        r_dc <= r_dc - 6'd1;
                    end else begin
                        r_idx <= (quo >= WIDTH_W'(n_act)) ? IW'(n_act - NW'(1)) : IW'(quo);
                        r_st <= S_RD;
                    end
                end
                S_RD: r_st <= S_WR;
                S_WR: begin
                    if (r_cmd.mode == MODE_ADD) begin
                        r_num <= 6'(r_idx);
                        r_val <= 32'((r_rdata != CMAX) ? r_rdata + COUNT_WIDTH'(1) : r_rdata);
                        if (r_idx > r_top) r_top <= r_idx;
                    end else begin
                        r_num <= r_cmd.bin_select;
                        r_val <= (32'(r_cmd.bin_select) < 32'(n_act)) ? 32'(r_rdata) : 32'd0;
                    end
                    r_st <= S_OUT;
                end
                S_CLR: begin
                    r_i <= r_i + NW'(1);
                    if (r_i == NMAX - NW'(1)) begin
                        r_top <= '0;
                        r_w <= (i_init_size == 16'd0) ? WIDTH_W'(1) : WIDTH_W'(i_init_size);
                        r_num <= '0; r_val <= '0;
                        r_st <= S_OUT;
                    end
                end
                S_OUT: if (out_load) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
        if (out_load) begin
            r_out.bin_number         <= r_num;
            r_out.bin_value          <= r_val;
            r_out.samples_seen       <= i_tally;
            r_out.largest_sample     <= i_max;
            r_out.running_sum        <= i_sum;
            r_out.running_square_sum <= i_sq;
            r_out.top_bin            <= 6'(r_top);
            r_out.current_width      <= r_w;
        end
    end

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !o_ready) else $error("busy back end ready");
    a_width_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_IDLE) |-> (r_w != '0)) else $error("zero bin width");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> r_ov) else $error("result dropped");
endmodule

/* rtl/auto_rebinning_histogram.sv */
// Top level of the auto-rebinning histogram.
// Each add takes one bin read-modify-write. A word waits in the queue
// until the back end is idle and takes it. A read passes through decode,
// read, result and output; a log2 add through decode, index, read, update
// and output; a linear add also checks the limit and does a bit-serial
// divide by the bin width. Each width doubling adds the merge sweep through
// the single-port bin memory (a read of each bin pair and a write of their
// saturated sum, then a clear of the upper half of the active bins) and a
// recheck of the limit. A clear sweeps all MAX_BINS entries, and the wake-up
// after reset sweeps all MAX_BINS entries while the back end takes no word.
// Running statistics are kept in the front end and updated as words move into
// the back end; a two-word queue and an output register decouple both sides.
module auto_rebinning_histogram #(
    parameter int MAX_BINS     = 64,
    parameter int COUNT_WIDTH  = 32,
    parameter int SAMPLE_WIDTH = 32
) (
    input logic    i_clk,
    input logic    i_rst_n,
    arh_cfg_if.sink   cfg,
    arh_in_if.sink    in_ch,
    arh_out_if.source out_ch
);
    import arh_pkg::*;

    logic        r_log;
    logic [15:0] r_init;
    logic [6:0]  r_bins;
    logic        q_valid, q_ready, clr;
    t_in_word    q_word;
    logic [31:0] st_max;
    logic [63:0] st_tally, st_sum, st_sq;

    assign cfg.ready = 1'b1;
    assign clr = 1'b0;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log <= 1'b0; r_init <= 16'd1; r_bins <= 7'd64;
        end else if (cfg.valid) begin
            case (cfg.data.index)
                CFG_LOG_SCALE: r_log  <= cfg.data.data[0];
                CFG_INIT_SIZE: r_init <= cfg.data.data;
                CFG_BINS:      r_bins <= cfg.data.data[6:0];
                default: ;
            endcase
        end
    end

    arh_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_clear_stats(clr),
        .i_valid(in_ch.valid), .o_ready(in_ch.ready), .i_word(in_ch.data),
        .o_valid(q_valid), .i_ready(q_ready), .o_word(q_word),
        .o_max(st_max), .o_tally(st_tally), .o_sum(st_sum), .o_sq(st_sq)
    );

    // NOTE: the back end takes one word at a time, so the statistics it
    // latches with a result cover exactly the words up to that one.
    arh_back #(.MAX_BINS(MAX_BINS), .COUNT_WIDTH(COUNT_WIDTH),
               .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
        .i_clk, .i_rst_n, .i_log_scale(r_log), .i_init_size(r_init),
        .i_bins(r_bins), .i_valid(q_valid), .o_ready(q_ready), .i_word(q_word),
        .i_max(st_max), .i_tally(st_tally), .i_sum(st_sum), .i_sq(st_sq),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready), .o_word(out_ch.data)
    );
endmodule
